// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/ptpa_pkg.sv -----
`default_nettype none

package ptpa_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_INSTR_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMPL_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INSTR_VOLUME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 3'd6;

    localparam logic [14:0] FREQ_LOW_RST  = 15'd300;
    localparam logic [14:0] FREQ_HIGH_RST = 15'd600;
    localparam logic [14:0] AMPL_LOW_RST  = 15'd0;
    localparam logic [14:0] AMPL_HIGH_RST = 15'd30000;
    localparam logic [10:0] VOLUME_RST    = 11'd1024;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [22:0] FREQ_MAX = 23'h7F_FFFF;
    localparam logic [14:0] AMPL_MAX = 15'h7FFF;

    // integer square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] bt;
        a = a_in;
        res = 64'd0;
        bt = 64'd1 << 62;
        while (bt > a) begin
            bt = bt >> 2;
        end
        while (bt != 64'd0) begin
            if (a >= res + bt) begin
                a = a - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Q30 value of 2^(2^-k), k = 1..16
    function automatic logic [30:0] exp_root(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 1; j < k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/position_to_pitch_amplitude.sv -----
// Channel  Dir  Handshake                Payload
// s_       in   s_tvalid / s_tready      tuser: object_present; tdata: pos_x, pos_y
// m_       out  m_tvalid / m_tready      tuser: voice_on; tdata: frequency_q8, amplitude
// cfg_     in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transfer per cycle unless the log2 unit is busy or the output stalls; the 16-step exp2 chain sets depth.
// After reset and after each write to freq_low or freq_high the log2 unit squares its
// mantissa once per step, 16 steps per register: s_tready stays low until both are done.
// Reset (aresetn low, synchronous) clears valid bits and restores register defaults.
// Each stage holds while its successor is full and stalled; empty stages keep filling.
`default_nettype none

`include "assert_macros.svh"

module position_to_pitch_amplitude
    import ptpa_pkg::*;
#(
    parameter int FRAME_W = 160,
    parameter int FRAME_H = 120
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // [9:0] pos_x, [19:10] pos_y
    input  wire logic                  s_tuser,   // [0] object_present
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,   // [22:0] frequency_q8, [38:23] amplitude
    output logic                       m_tuser,   // [0] voice_on
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NS = 22;
    localparam logic [9:0] FW = 10'(FRAME_W);
    localparam logic [9:0] FH = 10'(FRAME_H);

    // floor(n / FRAME_W) for n < 2^31 by reciprocal multiply
    localparam int N1 = 31;
    localparam int K1 = N1 + $clog2(FRAME_W);
    localparam int M1W = K1 + 1;
    localparam int M1LW = M1W / 2;
    localparam int M1HW = M1W - M1LW;
    localparam logic [M1W-1:0] M1 =
        M1W'(((64'd1 << K1) + 64'(FRAME_W) - 64'd1) / 64'(FRAME_W));
    localparam logic [31:0] BW = 32'(FRAME_W) << 20;

    // floor(a / FRAME_H) for a < 2^27
    localparam int N2 = 27;
    localparam int K2 = N2 + $clog2(FRAME_H);
    localparam int M2W = K2 + 1;
    localparam int M2LW = M2W / 2;
    localparam int M2HW = M2W - M2LW;
    localparam logic [M2W-1:0] M2 =
        M2W'(((64'd1 << K2) + 64'(FRAME_H) - 64'd1) / 64'(FRAME_H));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LDLO = 2'd1;
    localparam logic [1:0] ST_LOW  = 2'd2;
    localparam logic [1:0] ST_HIGH = 2'd3;

    // configuration registers
    logic        instr_en_reg;
    logic [14:0] freq_low_reg;
    logic [14:0] freq_high_reg;
    logic [14:0] ampl_low_reg;
    logic [14:0] ampl_high_reg;
    logic [10:0] instr_vol_reg;
    logic [10:0] master_vol_reg;

    // log2 unit
    logic [1:0]  lg_state_reg;
    logic        lg_high_reg;
    logic [3:0]  lg_cnt_reg;
    logic [30:0] lg_m_reg;
    logic [15:0] lg_frac_reg;
    logic [3:0]  lg_e_reg;
    logic [19:0] ll_reg;
    logic signed [20:0] d_reg;
    logic [14:0] lg_v;
    logic [3:0]  lg_e_next;
    logic [30:0] lg_m_load;
    logic [61:0] lg_sq;
    logic [31:0] lg_t;
    logic [30:0] lg_m_next;
    logic [15:0] lg_frac_next;
    logic        busy;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;
    assign busy = (lg_state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            instr_en_reg <= 1'b0;
            freq_low_reg <= FREQ_LOW_RST;
            freq_high_reg <= FREQ_HIGH_RST;
            ampl_low_reg <= AMPL_LOW_RST;
            ampl_high_reg <= AMPL_HIGH_RST;
            instr_vol_reg <= VOLUME_RST;
            master_vol_reg <= VOLUME_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INSTR_EN:      instr_en_reg <= cfg_data[0];
                REG_FREQ_LOW:      freq_low_reg <= cfg_data;
                REG_FREQ_HIGH:     freq_high_reg <= cfg_data;
                REG_AMPL_LOW:      ampl_low_reg <= cfg_data;
                REG_AMPL_HIGH:     ampl_high_reg <= cfg_data;
                REG_INSTR_VOLUME:  instr_vol_reg <= cfg_data[10:0];
                REG_MASTER_VOLUME: master_vol_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lg_v = lg_high_reg ? freq_high_reg : freq_low_reg;
        if (lg_v == 15'd0) begin
            lg_v = 15'd1;
        end
        lg_e_next = 4'd0;
        for (int b = 1; b < 15; b++) begin
            if (lg_v[b]) begin
                lg_e_next = 4'(b);
            end
        end
        lg_m_load = 31'({16'd0, lg_v} << (5'd30 - {1'b0, lg_e_next}));
        lg_sq = {31'd0, lg_m_reg} * {31'd0, lg_m_reg};
        lg_t = lg_sq[61:30];
        lg_m_next = lg_t[31] ? lg_t[31:1] : lg_t[30:0];
        lg_frac_next = {lg_frac_reg[14:0], lg_t[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_state_reg <= ST_LDLO;
            lg_high_reg <= 1'b0;
        end else if (cfg_we && (cfg_index == REG_FREQ_LOW || cfg_index == REG_FREQ_HIGH)) begin
            lg_state_reg <= ST_LDLO;
            lg_high_reg <= 1'b0;
        end else begin
            unique case (lg_state_reg)
                ST_IDLE: ;
                ST_LDLO: begin
                    lg_state_reg <= lg_high_reg ? ST_HIGH : ST_LOW;
                end
                ST_LOW: begin
                    if (lg_cnt_reg == 4'd15) begin
                        lg_state_reg <= ST_LDLO;
                        lg_high_reg <= 1'b1;
                    end
                end
                ST_HIGH: begin
                    if (lg_cnt_reg == 4'd15) begin
                        lg_state_reg <= ST_IDLE;
                    end
                end
                default: lg_state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (lg_state_reg == ST_LDLO) begin
            lg_m_reg <= lg_m_load;
            lg_e_reg <= lg_e_next;
            lg_frac_reg <= 16'd0;
            lg_cnt_reg <= 4'd0;
        end else if (busy) begin
            lg_m_reg <= lg_m_next;
            lg_frac_reg <= lg_frac_next;
            lg_cnt_reg <= lg_cnt_reg + 4'd1;
            if (lg_cnt_reg == 4'd15) begin
                if (lg_state_reg == ST_LOW) begin
                    ll_reg <= {lg_e_reg, lg_frac_next};
                end else begin
                    d_reg <= $signed({1'b0, lg_e_reg, lg_frac_next}) - $signed({1'b0, ll_reg});
                end
            end
        end
    end

    // pipeline control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] go;
    logic          s_accept;

    always_comb begin
        go[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            go[i] = !vld_reg[i] || go[i+1];
        end
    end

    assign s_tready = go[0] && !busy;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (go[0]) begin
                vld_reg[0] <= s_accept;
            end
            for (int i = 1; i < NS; i++) begin
                if (go[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // datapath
    logic [9:0]  xs;
    logic [9:0]  ys;
    logic        neg_in;
    logic [14:0] span;
    logic        voice_s [NS];
    logic        neg_s [4];
    logic signed [31:0] dx_reg;
    logic [24:0] a1_reg;
    logic [30:0] n_reg;
    logic [35:0] a2_reg;
    logic [N1+M1LW-1:0] ppl_reg;
    logic [N1+M1HW-1:0] pph_reg;
    logic [46:0] a3_reg;
    logic [N1+M1W:0] qsum;
    logic [26:0] a4;
    logic [N2+M2LW-1:0] apl_reg;
    logic [N2+M2HW-1:0] aph_reg;
    logic [N2+M2W:0] asum;
    logic [26:0] amag_full;
    logic [14:0] amag;
    logic [20:0] q_s [17];
    logic [30:0] r_s [1:16];
    logic [15:0] amp_s [4:NS-1];
    logic [14:0] fl_eff;
    logic [45:0] p_reg;
    logic [4:0]  ib_reg;
    logic [5:0]  sh;
    logic [45:0] f_full;
    logic [22:0] freq_reg;

    assign xs = (s_tdata[9:0] > FW) ? FW : s_tdata[9:0];
    assign ys = (s_tdata[19:10] > FH) ? FH : s_tdata[19:10];
    assign neg_in = ampl_high_reg < ampl_low_reg;
    assign span = neg_in ? (ampl_low_reg - ampl_high_reg) : (ampl_high_reg - ampl_low_reg);

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            voice_s[0] <= instr_en_reg && s_tuser;
            dx_reg <= 32'(d_reg) * 32'($signed({1'b0, xs}));
            a1_reg <= {10'd0, span} * {15'd0, ys};
            neg_s[0] <= neg_in;
        end
        if (go[1]) begin
            n_reg <= 31'(dx_reg + $signed(BW));
            a2_reg <= {11'd0, a1_reg} * {25'd0, instr_vol_reg};
            neg_s[1] <= neg_s[0];
        end
        if (go[2]) begin
            ppl_reg <= {{M1LW{1'b0}}, n_reg} * {{N1{1'b0}}, M1[M1LW-1:0]};
            pph_reg <= {{M1HW{1'b0}}, n_reg} * {{N1{1'b0}}, M1[M1W-1:M1LW]};
            a3_reg <= {11'd0, a2_reg} * {36'd0, master_vol_reg};
            neg_s[2] <= neg_s[1];
        end
        if (go[3]) begin
            q_s[0] <= qsum[K1+20:K1];
            apl_reg <= {{M2LW{1'b0}}, a4} * {{N2{1'b0}}, M2[M2LW-1:0]};
            aph_reg <= {{M2HW{1'b0}}, a4} * {{N2{1'b0}}, M2[M2W-1:M2LW]};
            neg_s[3] <= neg_s[2];
        end
        if (go[4]) begin
            if (!voice_s[3]) begin
                amp_s[4] <= 16'd0;
            end else if (neg_s[3]) begin
                amp_s[4] <= 16'd0 - {1'b0, amag};
            end else begin
                amp_s[4] <= {1'b0, amag};
            end
        end
        if (go[20]) begin
            p_reg <= {31'd0, fl_eff} * {15'd0, r_s[16]};
            ib_reg <= q_s[16][20:16];
        end
        if (go[21]) begin
            if (!voice_s[20]) begin
                freq_reg <= 23'd0;
            end else if (|f_full[45:23]) begin
                freq_reg <= FREQ_MAX;
            end else begin
                freq_reg <= f_full[22:0];
            end
        end
    end

    assign qsum = (N1+M1W+1)'({pph_reg, {M1LW{1'b0}}}) + (N1+M1W+1)'(ppl_reg);
    assign a4 = a3_reg[46:20];
    assign asum = (N2+M2W+1)'({aph_reg, {M2LW{1'b0}}}) + (N2+M2W+1)'(apl_reg);
    assign amag_full = asum[K2+26:K2];
    assign amag = (amag_full > 27'(AMPL_MAX)) ? AMPL_MAX : amag_full[14:0];
    assign fl_eff = (freq_low_reg == 15'd0) ? 15'd1 : freq_low_reg;
    assign sh = 6'(7'd38 - {2'd0, ib_reg});
    assign f_full = p_reg >> sh;

    genvar gi;
    generate
        for (gi = 1; gi < NS; gi++) begin : g_voice
            always_ff @(posedge aclk) begin
                if (go[gi]) begin
                    voice_s[gi] <= voice_s[gi-1];
                end
            end
        end
        for (gi = 5; gi < NS; gi++) begin : g_amp
            always_ff @(posedge aclk) begin
                if (go[gi]) begin
                    amp_s[gi] <= amp_s[gi-1];
                end
            end
        end
        for (gi = 1; gi <= 16; gi++) begin : g_exp
            localparam logic [30:0] CK = exp_root(gi);
            logic [30:0] r_in;
            logic [61:0] r_prod;
            if (gi == 1) begin : g_first
                assign r_in = Q30_ONE;
            end else begin : g_rest
                assign r_in = r_s[gi-1];
            end
            assign r_prod = {31'd0, r_in} * {31'd0, CK};
            always_ff @(posedge aclk) begin
                if (go[gi+3]) begin
                    r_s[gi] <= q_s[gi-1][16-gi] ? r_prod[60:30] : r_in;
                    q_s[gi] <= q_s[gi-1];
                end
            end
        end
    endgenerate

    assign m_tvalid = vld_reg[NS-1];
    assign m_tuser = voice_s[NS-1];
    assign m_tdata = {1'b0, amp_s[NS-1], freq_reg};

    `ASSERT_IMPL(a_busy_blocks_input, aclk, aresetn, busy, !s_tready)
    `ASSERT_IMPL(a_voice_off_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 40'd0)
    `ASSERT_NEXT(a_freq_write_relog, aclk, aresetn,
        cfg_valid && cfg_ready && cfg_index == REG_FREQ_LOW, lg_state_reg == ST_LDLO)

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
    import ptpa_pkg::*;

    localparam int FRAME_W = 160;
    localparam int FRAME_H = 120;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic        voice_on;
        logic [22:0] freq_q8;
        logic [15:0] ampl;
    } voice_t;

    class pitch_scoreboard;
        logic        en;
        logic [14:0] f_lo, f_hi, a_lo, a_hi;
        logic [10:0] vol_i, vol_m;
        logic [63:0] root_q30[1:16];
        voice_t      pending[$];
        int          errors;

        function new();
            en = 1'b0;
            f_lo = FREQ_LOW_RST;
            f_hi = FREQ_HIGH_RST;
            a_lo = AMPL_LOW_RST;
            a_hi = AMPL_HIGH_RST;
            vol_i = VOLUME_RST;
            vol_m = VOLUME_RST;
            errors = 0;
            root_q30[1] = floor_sqrt(64'd1 << 61);
            for (int k = 2; k <= 16; k++) begin
                root_q30[k] = floor_sqrt(root_q30[k-1] << 30);
            end
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] a);
            logic [63:0] r;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= a) begin
                    r = r | (64'd1 << b);
                end
            end
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_INSTR_EN:      en = d[0];
                REG_FREQ_LOW:      f_lo = d;
                REG_FREQ_HIGH:     f_hi = d;
                REG_AMPL_LOW:      a_lo = d;
                REG_AMPL_HIGH:     a_hi = d;
                REG_INSTR_VOLUME:  vol_i = d[10:0];
                REG_MASTER_VOLUME: vol_m = d[10:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] log2_q16(logic [14:0] v_in);
            logic [63:0] v;
            logic [63:0] m;
            logic [63:0] frac;
            int          e;
            v = (v_in == 0) ? 64'd1 : 64'(v_in);
            e = 0;
            for (int b = 0; b < 15; b++) begin
                if (v[b]) e = b;
            end
            m = v << (30 - e);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return (64'(e) << 16) | frac;
        endfunction

        function logic [22:0] pitch(logic [9:0] x);
            logic [63:0] xs, q, ib, r, p, f, fl;
            xs = (x > FRAME_W) ? 64'(FRAME_W) : 64'(x);
            fl = (f_lo == 0) ? 64'd1 : 64'(f_lo);
            q = (log2_q16(f_hi) * xs + (64'd16 << 16) * FRAME_W - log2_q16(f_lo) * xs)
                / FRAME_W;
            ib = q >> 16;
            r = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (q[16-k]) r = (r * root_q30[k]) >> 30;
            end
            p = fl * r;
            if (ib > 38) ib = 38;
            f = p >> (38 - ib);
            return (f > 64'(FREQ_MAX)) ? FREQ_MAX : f[22:0];
        endfunction

        function logic [15:0] loudness(logic [9:0] y);
            logic [63:0] ys, span, mag;
            logic        neg;
            ys = (y > FRAME_H) ? 64'(FRAME_H) : 64'(y);
            neg = a_hi < a_lo;
            span = neg ? 64'(a_lo - a_hi) : 64'(a_hi - a_lo);
            mag = (span * ys * 64'(vol_i) * 64'(vol_m)) / (64'(FRAME_H) << 20);
            if (mag > 32767) mag = 32767;
            return neg ? (16'd0 - mag[15:0]) : mag[15:0];
        endfunction

        function void note_input(logic present, logic [9:0] x, logic [9:0] y);
            voice_t v;
            v = '0;
            if (en && present) begin
                v.voice_on = 1'b1;
                v.freq_q8 = pitch(x);
                v.ampl = loudness(y);
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic voice, logic [22:0] freq, logic [15:0] ampl);
            voice_t v;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            v = pending.pop_front();
            if (voice !== v.voice_on) begin
                $error("voice_on exp %0d got %0d", v.voice_on, voice);
                errors++;
            end
            if (freq !== v.freq_q8) begin
                $error("frequency_q8 exp %0d got %0d", v.freq_q8, freq);
                errors++;
            end
            if (ampl !== v.ampl) begin
                $error("amplitude exp %0d got %0d", $signed(v.ampl), $signed(ampl));
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pitch_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  in_taken;
    bit  cfg_taken;
    int  cycles;

    position_to_pitch_amplitude #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        cfg_taken = aresetn && cfg_valid && cfg_ready;
        if (cfg_taken) sb.write_reg(cfg_index, cfg_data);
        if (in_taken) sb.note_input(s_tuser, s_tdata[9:0], s_tdata[19:10]);
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[22:0], m_tdata[38:23]);
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic present, logic [9:0] x, logic [9:0] y);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = present;
        s_tdata = {4'b0, y, x};
        do @(negedge aclk); while (!in_taken);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid = 1'b0;
    endtask

    // quiesce, then reprogram every register
    task automatic program_regs(logic en, logic [14:0] fl, logic [14:0] fh, logic [14:0] al,
                                logic [14:0] ah, logic [10:0] vi, logic [10:0] vm);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        write_reg(REG_INSTR_EN, 15'(en));
        write_reg(REG_FREQ_LOW, fl);
        write_reg(REG_FREQ_HIGH, fh);
        write_reg(REG_AMPL_LOW, al);
        write_reg(REG_AMPL_HIGH, ah);
        write_reg(REG_INSTR_VOLUME, 15'(vi));
        write_reg(REG_MASTER_VOLUME, 15'(vm));
    endtask

    task automatic random_items(int n);
        logic [9:0] x, y;
        for (int i = 0; i < n; i++) begin
            x = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(FRAME_W));
            y = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(FRAME_H));
            send_item($urandom_range(9) != 0, x, y);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        tx_idle_pct = 16;
        rx_idle_pct = 76;
        cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: instrument disabled
        send_item(1'b1, 10'd80, 10'd60);
        send_item(1'b0, 10'd1023, 10'd1023);
        program_regs(1'b1, 15'd300, 15'd600, 15'd0, 15'd30000, 11'd1024, 11'd1024);
        write_reg(REG_UNMAPPED, 15'h7FFF);
        send_item(1'b0, 10'd80, 10'd60);
        send_item(1'b1, 10'd0, 10'd0);
        send_item(1'b1, 10'd160, 10'd120);
        send_item(1'b1, 10'd161, 10'd121);
        send_item(1'b1, 10'd1023, 10'd1023);
        send_item(1'b1, 10'd80, 10'd60);
        send_item(1'b1, 10'd341, 10'd682);
        program_regs(1'b1, 15'd0, 15'd0, 15'd32767, 15'd0, 11'd2047, 11'd2047);
        send_item(1'b1, 10'd0, 10'd120);
        send_item(1'b1, 10'd160, 10'd1);
        send_item(1'b1, 10'd100, 10'd60);
        program_regs(1'b1, 15'd24000, 15'd1, 15'd0, 15'd32767, 11'd0, 11'd1024);
        send_item(1'b1, 10'd0, 10'd120);
        send_item(1'b1, 10'd160, 10'd120);
        program_regs(1'b1, 15'd1, 15'd32767, 15'd0, 15'd32767, 11'd2047, 11'd1);
        send_item(1'b1, 10'd0, 10'd120);
        send_item(1'b1, 10'd160, 10'd120);
        send_item(1'b1, 10'd159, 10'd119);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                tx_idle_pct = 76;
                rx_idle_pct = 16;
            end else if (ph == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph % 4)
                0: program_regs(1'b1, 15'($urandom_range(1, 24000)),
                                15'($urandom_range(1, 24000)),
                                15'($urandom), 15'($urandom), 11'($urandom_range(1024)),
                                11'($urandom_range(1024)));
                1: program_regs(1'b1, 15'($urandom), 15'($urandom), 15'($urandom),
                                15'($urandom), 11'($urandom), 11'($urandom));
                2: program_regs(1'b1, 15'd1, 15'd24000, 15'd32767, 15'd0, 11'd1024, 11'd1024);
                default: program_regs(ph != 7, 15'd24000, 15'd20, 15'd0, 15'd32767,
                                      11'd2047, 11'd2047);
            endcase
            random_items(200);
        end

        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
